[hdl/register_machine_execute_with_profiling_defines.svh]
// Assertion helpers shared by the register machine execute block.
`ifndef REGISTER_MACHINE_EXECUTE_WITH_PROFILING_DEFINES_SVH
`define REGISTER_MACHINE_EXECUTE_WITH_PROFILING_DEFINES_SVH

// Checked at every clock edge outside of reset.
`define RMX_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define RMX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/rmx_pkg.sv]
package rmx_pkg;

  localparam int NUM_REGS    = 256;
  localparam int REG_IDX_W   = 8;
  localparam int PROG_DEPTH  = 1024;
  localparam int PC_W        = 10;
  localparam int COUNT_WIDTH = 16;
  localparam int THRESH_W    = 16;
  localparam int DATA_W      = 64;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [THRESH_W-1:0]    HOT_RESET = THRESH_W'(50);

  typedef enum logic [3:0] {
    OP_MOVI  = 4'd0,
    OP_MOV   = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_SUBI  = 4'd4,
    OP_CMP   = 4'd5,
    OP_JNE   = 4'd6,
    OP_PRINT = 4'd7,
    OP_EXIT  = 4'd8
  } opcode_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_CLOSE = 2'd2
  } trace_event_t;

  typedef enum logic [1:0] {
    CFG_PROFILING = 2'd0,
    CFG_THRESHOLD = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [7:0]         dest_reg;
    logic [7:0]         src_reg;
    logic signed [31:0] immediate;
    logic [9:0]         instr_pc;
    logic               prev_is_compare;
    logic [7:0]         compare_reg;
    logic signed [31:0] compare_imm;
  } instr_t;

  typedef struct packed {
    logic signed [31:0] next_pc;
    logic               print_valid;
    logic signed [63:0] print_value;
    logic               halted;
    logic               was_recorded;
    logic [1:0]         trace_event;
    logic [9:0]         trace_head_pc;
  } result_t;

  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] addr;
    logic [DATA_W-1:0]    data;
  } rf_wr_t;

  typedef struct packed {
    logic                   en;
    logic [PC_W-1:0]        addr;
    logic [COUNT_WIDTH-1:0] data;
  } hit_wr_t;

  typedef struct packed {
    logic            active;
    logic [PC_W-1:0] head;
  } trace_state_t;

endpackage

[hdl/register_machine_execute_with_profiling.sv]
// An accepted instruction is captured in the execute stage; its result then moves
// into the result register once that register is empty or being emptied.
// Throughput: one instruction per cycle, held back by result_stall and, after
// reset, by the counter clearing pass. Reset (rst, synchronous, active high)
// empties the pipeline, clears the trace state and sets profiling_enabled to 1
// and the hot limit to 50; then a pass zeroes every back-edge counter
// while instr_stall stays high.
`include "register_machine_execute_with_profiling_defines.svh"

module register_machine_execute_with_profiling (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         instr_valid,
  output logic                         instr_stall,
  input  rmx_pkg::instr_t              instr,
  output logic                         result_valid,
  input  logic                         result_stall,
  output rmx_pkg::result_t             result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [rmx_pkg::THRESH_W-1:0] cfg_data
);
  import rmx_pkg::*;

  // The block is a two-stage pipe. At the edge that accepts a transaction, the
  // register file and the counter table are read with addresses taken straight
  // from the instruction, and the instruction is captured in the execute stage.
  // In the following cycle the execute logic works out the result and the state
  // updates; both are committed at the edge that moves the result into the
  // output register. Apart from the clearing pass, only that commit writes
  // state, so each memory needs just one bypass register: it holds the most
  // recent write, which is the one a read on the same edge could have missed.

  logic                   s1_valid;
  instr_t                 s1_item;
  logic                   s1_adv;
  logic                   accept;
  logic                   hit_busy;

  logic                   profiling_enabled;
  logic [THRESH_W-1:0]    hot_limit;
  trace_state_t           trace;

  logic [DATA_W-1:0]      opnd_a;
  logic [DATA_W-1:0]      opnd_b;
  logic [COUNT_WIDTH-1:0] hit_count;
  logic [REG_IDX_W-1:0]   rd_addr_a;

  result_t                exec_res;
  rf_wr_t                 exec_rf_wr;
  hit_wr_t                exec_hit_wr;
  trace_state_t           trace_next;
  rf_wr_t                 rf_wr;
  hit_wr_t                hit_wr;

  // The execute stage moves on whenever the output register is empty or is
  // being emptied in this cycle, so a result that is taken downstream in this
  // cycle does not keep a new transaction from entering.
  assign s1_adv      = s1_valid && (!result_valid || !result_stall);
  assign instr_stall = hit_busy || (s1_valid && !s1_adv);
  assign accept      = instr_valid && !instr_stall;

  // A JNE compares the register named by the preceding CMP; every other
  // instruction reads its destination register on the first port.
  assign rd_addr_a = (instr.opcode == OP_JNE) ? instr.compare_reg : instr.dest_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= instr;
    end
  end

  rmx_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (instr.src_reg),
    .wr        (rf_wr),
    .rd_data_a (opnd_a),
    .rd_data_b (opnd_b)
  );

  // The counter table is indexed by the low bits of the jump target; the
  // execute logic ignores the count when the target lies outside the program.
  rmx_hit_table u_hit_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (instr.immediate[PC_W-1:0]),
    .wr       (hit_wr),
    .rd_count (hit_count),
    .busy     (hit_busy)
  );

  rmx_exec u_exec (
    .instr             (s1_item),
    .opnd_a            (opnd_a),
    .opnd_b            (opnd_b),
    .hit_count         (hit_count),
    .profiling_enabled (profiling_enabled),
    .hot_limit         (hot_limit),
    .trace             (trace),
    .res               (exec_res),
    .rf_wr             (exec_rf_wr),
    .hit_wr            (exec_hit_wr),
    .trace_next        (trace_next)
  );

  // State is written only by the instruction that is leaving the execute stage.
  always_comb begin
    rf_wr     = exec_rf_wr;
    rf_wr.en  = exec_rf_wr.en && s1_adv;
    hit_wr    = exec_hit_wr;
    hit_wr.en = exec_hit_wr.en && s1_adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trace <= '{active: 1'b0, head: '0};
    end else if (s1_adv) begin
      trace <= trace_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result <= exec_res;
    end
  end

  // Configuration writes are always taken; indexes past the register list are
  // dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      profiling_enabled <= 1'b1;
      hot_limit         <= HOT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PROFILING: profiling_enabled <= cfg_data[0];
        CFG_THRESHOLD: hot_limit         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  `RMX_ASSERT_CLK(a_close_was_recorded, (result_valid && result.trace_event == EV_CLOSE) |-> result.was_recorded, "trace closed by an instruction that was not recorded")
  `RMX_ASSERT_CLK(a_start_not_recorded, (result_valid && result.trace_event == EV_START) |-> !result.was_recorded, "trace started while another trace was recording")
  `RMX_ASSERT_CLK(a_start_sets_trace, (s1_adv && exec_res.trace_event == EV_START) |=> (trace.active && trace.head == $past(exec_res.trace_head_pc)), "trace start did not load the trace head")
  `RMX_ASSERT_CLK(a_idle_while_clearing, hit_busy |-> !s1_valid, "instruction in flight during the counter clearing pass")
  `RMX_ASSERT_ALWAYS(a_reset_empties, rst |=> (!result_valid && !s1_valid), "pipeline not empty after reset")

endmodule

[hdl/rmx_regfile.sv]
module rmx_regfile (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [rmx_pkg::REG_IDX_W-1:0] rd_addr_a,
  input  logic [rmx_pkg::REG_IDX_W-1:0] rd_addr_b,
  input  rmx_pkg::rf_wr_t               wr,
  output logic [rmx_pkg::DATA_W-1:0]    rd_data_a,
  output logic [rmx_pkg::DATA_W-1:0]    rd_data_b
);
  import rmx_pkg::*;

  localparam int AW = REG_IDX_W + 1;

  logic [DATA_W-1:0]    mem [NUM_REGS];
  logic [NUM_REGS-1:0]  valid;
  logic [REG_IDX_W-1:0] addr_a;
  logic [REG_IDX_W-1:0] addr_b;
  logic [DATA_W-1:0]    mem_a;
  logic [DATA_W-1:0]    mem_b;
  rf_wr_t               fwd;
  logic                 wr_ok;

  assign wr_ok = wr.en && (AW'(wr.addr) < AW'(NUM_REGS));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      addr_a <= rd_addr_a;
      addr_b <= rd_addr_b;
      mem_a  <= mem[rd_addr_a];
      mem_b  <= mem[rd_addr_b];
    end
  end

  // The latest write is kept aside, since the read that shares its edge
  // returns the old contents.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      fwd.en <= 1'b0;
    end else if (wr_ok) begin
      valid[wr.addr] <= 1'b1;
      fwd            <= wr;
    end
  end

  always_comb begin
    if (AW'(addr_a) >= AW'(NUM_REGS)) begin
      rd_data_a = '0;
    end else if (fwd.en && fwd.addr == addr_a) begin
      rd_data_a = fwd.data;
    end else if (valid[addr_a]) begin
      rd_data_a = mem_a;
    end else begin
      rd_data_a = '0;
    end
  end

  always_comb begin
    if (AW'(addr_b) >= AW'(NUM_REGS)) begin
      rd_data_b = '0;
    end else if (fwd.en && fwd.addr == addr_b) begin
      rd_data_b = fwd.data;
    end else if (valid[addr_b]) begin
      rd_data_b = mem_b;
    end else begin
      rd_data_b = '0;
    end
  end

endmodule

[hdl/rmx_hit_table.sv]
module rmx_hit_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [rmx_pkg::PC_W-1:0]        rd_addr,
  input  rmx_pkg::hit_wr_t                wr,
  output logic [rmx_pkg::COUNT_WIDTH-1:0] rd_count,
  output logic                            busy
);
  import rmx_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [PROG_DEPTH];
  logic [PC_W-1:0]        clr_idx;
  logic [PC_W-1:0]        addr_q;
  logic [COUNT_WIDTH-1:0] mem_q;
  hit_wr_t                fwd;
  hit_wr_t                port;

  // The clearing pass owns the write port until every counter is zero.
  always_comb begin
    if (busy) begin
      port = '{en: 1'b1, addr: clr_idx, data: '0};
    end else begin
      port = wr;
    end
  end

  always_ff @(posedge clk) begin
    if (port.en) begin
      mem[port.addr] <= port.data;
    end
    if (rd_en) begin
      addr_q <= rd_addr;
      mem_q  <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
      fwd.en  <= 1'b0;
    end else if (busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == PC_W'(PROG_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end else if (wr.en) begin
      fwd <= wr;
    end
  end

  assign rd_count = (fwd.en && fwd.addr == addr_q) ? fwd.data : mem_q;

endmodule

[hdl/rmx_exec.sv]
module rmx_exec (
  input  rmx_pkg::instr_t                 instr,
  input  logic [rmx_pkg::DATA_W-1:0]      opnd_a,
  input  logic [rmx_pkg::DATA_W-1:0]      opnd_b,
  input  logic [rmx_pkg::COUNT_WIDTH-1:0] hit_count,
  input  logic                            profiling_enabled,
  input  logic [rmx_pkg::THRESH_W-1:0]    hot_limit,
  input  rmx_pkg::trace_state_t           trace,
  output rmx_pkg::result_t                res,
  output rmx_pkg::rf_wr_t                 rf_wr,
  output rmx_pkg::hit_wr_t                hit_wr,
  output rmx_pkg::trace_state_t           trace_next
);
  import rmx_pkg::*;

  logic [DATA_W-1:0]      imm64;
  logic [DATA_W-1:0]      cimm64;
  logic signed [31:0]     pc32;
  logic                   taken;
  logic                   back_edge;
  logic                   in_range;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [PC_W-1:0]        tgt_idx;

  assign imm64   = {{32{instr.immediate[31]}}, instr.immediate};
  assign cimm64  = {{32{instr.compare_imm[31]}}, instr.compare_imm};
  assign pc32    = signed'(32'(instr.instr_pc));
  assign taken   = instr.prev_is_compare && (instr.instr_pc != '0) && (opnd_a != cimm64);
  assign back_edge = instr.immediate <= pc32;
  assign in_range  = !instr.immediate[31] &&
                     ($unsigned(instr.immediate) < 32'(PROG_DEPTH));
  assign tgt_idx   = instr.immediate[PC_W-1:0];
  assign cnt_inc   = (hit_count == COUNT_MAX) ? hit_count : hit_count + 1'b1;

  always_comb begin
    res.next_pc       = pc32 + 32'sd1;
    res.print_valid   = 1'b0;
    res.print_value   = '0;
    res.halted        = 1'b0;
    res.was_recorded  = trace.active;
    res.trace_event   = EV_NONE;
    res.trace_head_pc = '0;
    rf_wr             = '0;
    hit_wr            = '0;
    trace_next        = trace;

    unique case (instr.opcode)
      OP_MOVI:  rf_wr = '{en: 1'b1, addr: instr.dest_reg, data: imm64};
      OP_MOV:   rf_wr = '{en: 1'b1, addr: instr.dest_reg, data: opnd_b};
      OP_ADD:   rf_wr = '{en: 1'b1, addr: instr.dest_reg, data: opnd_a + opnd_b};
      OP_SUB:   rf_wr = '{en: 1'b1, addr: instr.dest_reg, data: opnd_a - opnd_b};
      OP_SUBI:  rf_wr = '{en: 1'b1, addr: instr.dest_reg, data: opnd_a - imm64};
      OP_CMP: begin
      end
      OP_JNE: begin
        if (taken) begin
          if (back_edge) begin
            if (profiling_enabled && !trace.active) begin
              if (in_range) begin
                hit_wr = '{en: 1'b1, addr: tgt_idx, data: cnt_inc};
                if (32'(cnt_inc) > 32'(hot_limit)) begin
                  trace_next        = '{active: 1'b1, head: tgt_idx};
                  res.trace_event   = EV_START;
                  res.trace_head_pc = tgt_idx;
                end
              end
            end else if (trace.active &&
                         instr.immediate == signed'(32'(trace.head))) begin
              trace_next.active = 1'b0;
              res.trace_event   = EV_CLOSE;
              res.trace_head_pc = trace.head;
            end
          end
          res.next_pc = instr.immediate;
        end else begin
          trace_next.active = 1'b0;
        end
      end
      OP_PRINT: begin
        res.print_valid = 1'b1;
        res.print_value = opnd_a;
      end
      OP_EXIT: begin
        res.halted  = 1'b1;
        res.next_pc = pc32;
      end
      default: begin
      end
    endcase
  end

endmodule
